>>> rtl/nsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared constants, codes and types of the nearest seed labeler.
// ----------------------------------------------------------------------------
package nsl_pkg;

   localparam int MAX_SEEDS  = 64;
   localparam int COORD_BITS = 12;

   // fixed field widths
   localparam int SLOT_BITS   = 6;
   localparam int RSQ_BITS    = 25;
   localparam int TYPE_BITS   = 3;
   localparam int ACTIVE_BITS = 7;
   localparam int OUT_DIST_BITS = 25;

   // derived widths
   localparam int IDX_BITS  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_SEEDS + 1);
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = SQ_BITS + 1;
   localparam int CMP_BITS  = (DIST_BITS > RSQ_BITS) ? DIST_BITS : RSQ_BITS;

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  capped;
      logic [RSQ_BITS-1:0]   rsq;
      logic [TYPE_BITS-1:0]  stype;
   } seed_entry_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  seed_slot;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
      logic                  radius_capped;
      logic [RSQ_BITS-1:0]   radius_sq;
      logic [TYPE_BITS-1:0]  seed_type;
   } req_payload_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_BITS-1:0] owner_index;
      logic [TYPE_BITS-1:0] biome_type;
      logic [OUT_DIST_BITS-1:0] best_dist_sq;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic                wr_en;
      logic                start;
      logic                issue;
      logic [IDX_BITS-1:0] issue_addr;
      logic                load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

endpackage

>>> rtl/nsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_if
// Valid/ready channels of the nearest seed labeler.
// ----------------------------------------------------------------------------
interface nsl_req_if import nsl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [SLOT_BITS-1:0]  seed_slot;
   logic [COORD_BITS-1:0] coord_x;
   logic [COORD_BITS-1:0] coord_y;
   logic                  radius_capped;
   logic [RSQ_BITS-1:0]   radius_sq;
   logic [TYPE_BITS-1:0]  seed_type;

   modport source (output valid, opcode, seed_slot, coord_x, coord_y, radius_capped,
                   radius_sq, seed_type, input ready);
   modport sink (input valid, opcode, seed_slot, coord_x, coord_y, radius_capped,
                 radius_sq, seed_type, output ready);
endinterface

interface nsl_rsp_if import nsl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [SLOT_BITS-1:0]     owner_index;
   logic [TYPE_BITS-1:0]     biome_type;
   logic [OUT_DIST_BITS-1:0] best_dist_sq;

   modport source (output valid, found, owner_index, biome_type, best_dist_sq,
                   input ready);
   modport sink (input valid, found, owner_index, biome_type, best_dist_sq,
                 output ready);
endinterface

interface nsl_csr_if import nsl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTIVE_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/nsl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_datapath
// Seed table memory, distance pipeline and running nearest-seed tracker.
// ----------------------------------------------------------------------------
module nsl_datapath import nsl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   input  req_payload_type req,
   output dp_status_type   status,
   output rsp_payload_type rsp
);

   seed_entry_type mem [MAX_SEEDS];

   seed_entry_type entry_w;
   logic           slot_ok;

   // stage r: table read
   seed_entry_type      rd_q_ff;
   logic [IDX_BITS-1:0] rd_idx_ff;
   logic                rd_v_ff, rd_v_in;

   // stage a: absolute differences
   logic [COORD_BITS-1:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic                  a_capped_ff;
   logic [RSQ_BITS-1:0]   a_rsq_ff;
   logic [TYPE_BITS-1:0]  a_type_ff;
   logic [IDX_BITS-1:0]   a_idx_ff;
   logic                  a_v_ff, a_v_in;

   // stage b: squares
   logic [SQ_BITS-1:0]   b_sqx_ff, b_sqx_in, b_sqy_ff, b_sqy_in;
   logic                 b_capped_ff;
   logic [RSQ_BITS-1:0]  b_rsq_ff;
   logic [TYPE_BITS-1:0] b_type_ff;
   logic [IDX_BITS-1:0]  b_idx_ff;
   logic                 b_v_ff, b_v_in;

   // stage c: distance sum
   logic [DIST_BITS-1:0] c_d_ff, c_d_in;
   logic                 c_capped_ff;
   logic [RSQ_BITS-1:0]  c_rsq_ff;
   logic [TYPE_BITS-1:0] c_type_ff;
   logic [IDX_BITS-1:0]  c_idx_ff;
   logic                 c_v_ff, c_v_in;

   // pixel and best-so-far
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic                  best_found_ff, best_found_in;
   logic [DIST_BITS-1:0]  best_d_ff;
   logic [TYPE_BITS-1:0]  best_type_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;
   logic                  reach, upd;

   rsp_payload_type out_ff;

   assign entry_w.x      = req.coord_x;
   assign entry_w.y      = req.coord_y;
   assign entry_w.capped = req.radius_capped;
   assign entry_w.rsq    = req.radius_sq;
   assign entry_w.stype  = req.seed_type;
   assign slot_ok        = 32'(req.seed_slot) < MAX_SEEDS;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && slot_ok) begin
         mem[IDX_BITS'(req.seed_slot)] <= entry_w;
      end
      if (cmd.issue) begin
         rd_q_ff <= mem[cmd.issue_addr];
      end
   end

   always_comb begin
      rd_v_in  = cmd.issue;
      a_v_in   = rd_v_ff;
      b_v_in   = a_v_ff;
      c_v_in   = b_v_ff;
      a_dx_in  = (rd_q_ff.x >= px_ff) ? rd_q_ff.x - px_ff : px_ff - rd_q_ff.x;
      a_dy_in  = (rd_q_ff.y >= py_ff) ? rd_q_ff.y - py_ff : py_ff - rd_q_ff.y;
      b_sqx_in = SQ_BITS'(a_dx_ff) * SQ_BITS'(a_dx_ff);
      b_sqy_in = SQ_BITS'(a_dy_ff) * SQ_BITS'(a_dy_ff);
      c_d_in   = DIST_BITS'(b_sqx_ff) + DIST_BITS'(b_sqy_ff);
   end

   // capped seeds only reach pixels within their radius
   assign reach = !c_capped_ff || (CMP_BITS'(c_d_ff) <= CMP_BITS'(c_rsq_ff));
   // strict compare keeps the lowest slot on ties
   assign upd   = c_v_ff && reach && (!best_found_ff || c_d_ff < best_d_ff);

   always_comb begin
      best_found_in = best_found_ff;
      if (cmd.start) begin
         best_found_in = 1'b0;
      end else if (upd) begin
         best_found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff       <= 1'b0;
         a_v_ff        <= 1'b0;
         b_v_ff        <= 1'b0;
         c_v_ff        <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         rd_v_ff       <= rd_v_in;
         a_v_ff        <= a_v_in;
         b_v_ff        <= b_v_in;
         c_v_ff        <= c_v_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_idx_ff <= cmd.issue_addr;
      end
      a_dx_ff     <= a_dx_in;
      a_dy_ff     <= a_dy_in;
      a_capped_ff <= rd_q_ff.capped;
      a_rsq_ff    <= rd_q_ff.rsq;
      a_type_ff   <= rd_q_ff.stype;
      a_idx_ff    <= rd_idx_ff;
      b_sqx_ff    <= b_sqx_in;
      b_sqy_ff    <= b_sqy_in;
      b_capped_ff <= a_capped_ff;
      b_rsq_ff    <= a_rsq_ff;
      b_type_ff   <= a_type_ff;
      b_idx_ff    <= a_idx_ff;
      c_d_ff      <= c_d_in;
      c_capped_ff <= b_capped_ff;
      c_rsq_ff    <= b_rsq_ff;
      c_type_ff   <= b_type_ff;
      c_idx_ff    <= b_idx_ff;
      if (cmd.start) begin
         px_ff <= req.coord_x;
         py_ff <= req.coord_y;
      end
      if (upd) begin
         best_d_ff    <= c_d_ff;
         best_type_ff <= c_type_ff;
         best_idx_ff  <= c_idx_ff;
      end
      if (cmd.load_out) begin
         out_ff.found        <= best_found_ff;
         out_ff.owner_index  <= best_found_ff ? SLOT_BITS'(best_idx_ff) : '0;
         out_ff.biome_type   <= best_found_ff ? best_type_ff : '0;
         out_ff.best_dist_sq <= best_found_ff ? OUT_DIST_BITS'(best_d_ff) : '0;
      end
   end

   assign status.pipe_busy = rd_v_ff | a_v_ff | b_v_ff | c_v_ff;
   assign rsp              = out_ff;

   // a new query must not start while an earlier seed is still in flight
   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.pipe_busy)
      else $error("query started with distance pipeline busy");

   // the result is taken only after the last comparison has landed
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !c_v_ff && !cmd.issue)
      else $error("result loaded while comparisons pending");

   // the best distance never grows during a scan
   assert property (@(posedge clock) disable iff (reset)
      (upd && best_found_ff) |=> best_d_ff < $past(best_d_ff))
      else $error("best distance increased");

endmodule

>>> rtl/nsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsl_ctrl
// Sequencer: request handshake, slot scan, drain and result handshake.
// ----------------------------------------------------------------------------
module nsl_ctrl import nsl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   input  logic [ACTIVE_BITS-1:0] csr_data,
   output logic                   csr_ready,
   output dp_cmd_type             cmd,
   input  dp_status_type          status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    idx_next;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [CNT_BITS-1:0]    n_seeds;
   logic                   rsp_valid_ff, rsp_valid_in;

   // counts above the table size saturate
   assign n_seeds  = (32'(active_ff) > MAX_SEEDS) ? CNT_BITS'(MAX_SEEDS)
                                                  : CNT_BITS'(active_ff);
   assign idx_next = idx_ff + CNT_BITS'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      cmd       = '0;
      if (csr_valid) begin
         active_in = csr_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  idx_in    = '0;
                  state_in  = (n_seeds == '0) ? ST_DRAIN : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue      = 1'b1;
            cmd.issue_addr = idx_ff[IDX_BITS-1:0];
            idx_in         = idx_next;
            if (idx_next == n_seeds) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the pipeline to empty and the output register to free up
            if (!status.pipe_busy && (!rsp_valid_ff || rsp_ready)) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // every issued slot lies inside the searched range
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> idx_ff < n_seeds)
      else $error("slot issued beyond active range");

   // a pending transaction on the result side is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load_out)
      else $error("result overwritten before it was taken");

   // a query leaves the scan only after the last active slot was issued
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in == ST_DRAIN) |=> idx_ff == n_seeds)
      else $error("scan ended early");

endmodule

>>> rtl/nearest_seed_labeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_seed_labeler
// Nearest-seed (Voronoi) labeler over a table of seeds with optional reach.
// ----------------------------------------------------------------------------
// write transaction: one per cycle while no query is in progress, no result
// query transaction: result loaded after the scan and drain, n = active seeds
//   (scan skipped when n is zero); one table read per cycle during the scan
// a new transaction can be taken in the cycle after the result is loaded
// reset clears control state and active_seeds; the seed table is not cleared
module nearest_seed_labeler import nsl_pkg::*; (
   input logic clock,
   input logic reset,
   nsl_req_if.sink   req_ch,
   nsl_rsp_if.source rsp_ch,
   nsl_csr_if.sink   csr_ch
);

   dp_cmd_type      cmd;
   dp_status_type   status;
   req_payload_type req_pl;
   rsp_payload_type rsp_pl;

   assign req_pl.seed_slot     = req_ch.seed_slot;
   assign req_pl.coord_x       = req_ch.coord_x;
   assign req_pl.coord_y       = req_ch.coord_y;
   assign req_pl.radius_capped = req_ch.radius_capped;
   assign req_pl.radius_sq     = req_ch.radius_sq;
   assign req_pl.seed_type     = req_ch.seed_type;

   nsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .csr_valid  (csr_ch.valid),
      .csr_data   (csr_ch.data),
      .csr_ready  (csr_ch.ready),
      .cmd        (cmd),
      .status     (status)
   );

   nsl_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req    (req_pl),
      .status (status),
      .rsp    (rsp_pl)
   );

   assign rsp_ch.found        = rsp_pl.found;
   assign rsp_ch.owner_index  = rsp_pl.owner_index;
   assign rsp_ch.biome_type   = rsp_pl.biome_type;
   assign rsp_ch.best_dist_sq = rsp_pl.best_dist_sq;

endmodule
